>>> rtl/core/dpid_pkg.sv
// ----------------------------------------------------------------------------
// dpid_pkg
// Shared widths, codes and payload types of the drive-distance PID block.
// ----------------------------------------------------------------------------
package dpid_pkg;

  localparam int POSITION_BITS = 32;
  localparam int INTEGRAL_BITS = 48;

  localparam int GAIN_W      = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int BAND_W      = 16;
  localparam int TICK_W      = 10;
  localparam int LIMIT_W     = 15;
  localparam int DRIVE_W     = 16;
  localparam int STATUS_W    = 2;
  localparam int GAIN_SHIFT  = 12;

  localparam int SCALE_W     = 18;
  localparam logic signed [SCALE_W-1:0] DIST_SCALE = 18'sd117342;
  localparam int ROUND_SHIFT = 16;
  localparam int TPROD_W     = GAIN_W + SCALE_W;
  localparam int TARGET_W    = TPROD_W - ROUND_SHIFT;
  localparam logic signed [TPROD_W-1:0] ROUND_HALF = TPROD_W'(32768);

  localparam int DIFF_W    = POSITION_BITS + 1;
  localparam int LR_W      = POSITION_BITS + 2;
  localparam int AVG_W     = POSITION_BITS + 1;
  localparam int ERR_RAW_W = ((AVG_W > TARGET_W) ? AVG_W : TARGET_W) + 1;
  localparam int DERIV_W   = POSITION_BITS + 1;
  localparam int SUM_RAW_W = ((INTEGRAL_BITS > POSITION_BITS) ? INTEGRAL_BITS
                                                              : POSITION_BITS) + 1;
  localparam int I_LO_W    = INTEGRAL_BITS / 2;
  localparam int I_HI_W    = INTEGRAL_BITS - I_LO_W;

  localparam int PP_W    = GAIN_W + POSITION_BITS;
  localparam int PILO_W  = GAIN_W + I_LO_W + 1;
  localparam int PIHI_W  = GAIN_W + I_HI_W;
  localparam int PD_W    = GAIN_W + DERIV_W;
  localparam int ACC_W   = GAIN_W + INTEGRAL_BITS + 2;
  localparam int QUO_W   = ACC_W - GAIN_SHIFT;

  localparam int S_DATA_W   = ((2 * POSITION_BITS + 7) / 8) * 8;
  localparam int DRIVE_LSB  = 0;
  localparam int STATUS_LSB = DRIVE_W;
  localparam int ERROR_LSB  = DRIVE_W + STATUS_W;
  localparam int OUT_BITS   = ERROR_LSB + POSITION_BITS;
  localparam int M_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};
  localparam logic [INTEGRAL_BITS-1:0] INT_MAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
  localparam logic [INTEGRAL_BITS-1:0] INT_MIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};
  localparam logic [TICK_W-1:0]        TICK_MAX = {TICK_W{1'b1}};

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUNNING = 2'd0,
    ST_SETTLED = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_P_GAIN = 3'd1,
    REG_I_GAIN = 3'd2,
    REG_D_GAIN = 3'd3,
    REG_BAND   = 3'd4,
    REG_MAX    = 3'd5,
    REG_LIMIT  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] p_gain;
    logic signed [GAIN_W-1:0] i_gain;
    logic signed [GAIN_W-1:0] d_gain;
    logic [LIMIT_W-1:0]       output_limit;
  } gain_set_t;

  typedef struct packed {
    logic signed [TARGET_W-1:0] target;
    logic [BAND_W-1:0]          settle_band;
    logic [TICK_W-1:0]          max_ticks;
  } move_set_t;

  typedef struct packed {
    logic signed [POSITION_BITS-1:0] err;
    logic signed [INTEGRAL_BITS-1:0] err_sum;
    logic signed [DERIV_W-1:0]       deriv;
    status_t                         status;
    logic                            hold;
  } track_t;

endpackage

>>> rtl/core/dpid_cfg.sv
// ----------------------------------------------------------------------------
// dpid_cfg
// Configuration registers and the registered target distance in 1/16 degree.
// ----------------------------------------------------------------------------
module dpid_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dpid_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dpid_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dpid_pkg::gain_set_t               gains,
  output dpid_pkg::move_set_t               move
);
  import dpid_pkg::*;

  logic signed [GAIN_W-1:0]   p_gain;
  logic signed [GAIN_W-1:0]   i_gain;
  logic signed [GAIN_W-1:0]   d_gain;
  logic [BAND_W-1:0]          settle_band;
  logic [TICK_W-1:0]          max_ticks;
  logic [LIMIT_W-1:0]         output_limit;
  logic signed [TARGET_W-1:0] target;
  logic signed [TPROD_W-1:0]  target_round;

  // Inches in 1/256 to degrees in 1/16 for a 4-inch wheel, rounded.
  assign target_round = TPROD_W'($signed(cfg_data[GAIN_W-1:0])) * TPROD_W'(DIST_SCALE)
                      + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      target       <= '0;
      p_gain       <= '0;
      i_gain       <= '0;
      d_gain       <= '0;
      settle_band  <= BAND_W'(80);
      max_ticks    <= TICK_W'(150);
      output_limit <= LIMIT_W'(25600);
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        REG_TARGET: target       <= target_round[ROUND_SHIFT +: TARGET_W];
        REG_P_GAIN: p_gain       <= cfg_data[GAIN_W-1:0];
        REG_I_GAIN: i_gain       <= cfg_data[GAIN_W-1:0];
        REG_D_GAIN: d_gain       <= cfg_data[GAIN_W-1:0];
        REG_BAND:   settle_band  <= cfg_data[BAND_W-1:0];
        REG_MAX:    max_ticks    <= cfg_data[TICK_W-1:0];
        REG_LIMIT:  output_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign gains.p_gain       = p_gain;
  assign gains.i_gain       = i_gain;
  assign gains.d_gain       = d_gain;
  assign gains.output_limit = output_limit;
  assign move.target        = target;
  assign move.settle_band   = settle_band;
  assign move.max_ticks     = max_ticks;

endmodule

>>> rtl/core/dpid_track.sv
// ----------------------------------------------------------------------------
// dpid_track
// Input register and move tracking: error, integral, derivative and status.
// ----------------------------------------------------------------------------
module dpid_track (
  input  logic                                      clk,
  input  logic                                      rst,
  input  dpid_pkg::move_set_t                       move,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic                                      in_action,
  input  logic signed [dpid_pkg::POSITION_BITS-1:0] in_left,
  input  logic signed [dpid_pkg::POSITION_BITS-1:0] in_right,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output dpid_pkg::track_t                          out_track
);
  import dpid_pkg::*;

  logic                             v1;
  logic                             action;
  logic signed [POSITION_BITS-1:0]  left;
  logic signed [POSITION_BITS-1:0]  right;
  logic signed [POSITION_BITS-1:0]  left_origin;
  logic signed [POSITION_BITS-1:0]  right_origin;
  logic signed [INTEGRAL_BITS-1:0]  error_sum;
  logic signed [POSITION_BITS-1:0]  last_error;
  logic [TICK_W-1:0]                tick_count;
  status_t                          run_status;
  logic                             v2;
  track_t                           track;

  logic                             adv2;
  logic                             take;
  logic signed [DIFF_W-1:0]         dl;
  logic signed [DIFF_W-1:0]         dr;
  logic signed [LR_W-1:0]           lr_sum;
  logic signed [AVG_W-1:0]          avg;
  logic signed [ERR_RAW_W-1:0]      err_raw;
  logic [ERR_RAW_W-POSITION_BITS:0] err_top;
  logic signed [POSITION_BITS-1:0]  err_sat;
  logic signed [SUM_RAW_W-1:0]      sum_raw;
  logic [SUM_RAW_W-INTEGRAL_BITS:0] sum_top;
  logic signed [INTEGRAL_BITS-1:0]  sum_sat;
  logic [POSITION_BITS:0]           err_abs;
  logic [TICK_W-1:0]                tick_count_next;
  logic                             settled;
  logic                             timed_out;
  track_t                           track_next;

  assign adv2     = !v2 || out_ready;
  assign take     = v1 && adv2;
  assign in_ready = !v1 || adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      action <= in_action;
      left   <= in_left;
      right  <= in_right;
    end
  end

  // Average travel of both wheels, floored, against the target.
  assign dl      = DIFF_W'(left) - DIFF_W'(left_origin);
  assign dr      = DIFF_W'(right) - DIFF_W'(right_origin);
  assign lr_sum  = LR_W'(dl) + LR_W'(dr);
  assign avg     = lr_sum[LR_W-1:1];
  assign err_raw = ERR_RAW_W'(move.target) - ERR_RAW_W'(avg);
  assign err_top = err_raw[ERR_RAW_W-1:POSITION_BITS-1];
  assign err_sat = ((&err_top) || !(|err_top)) ? err_raw[POSITION_BITS-1:0]
                 : (err_raw[ERR_RAW_W-1] ? POS_MIN : POS_MAX);

  assign sum_raw = SUM_RAW_W'(error_sum) + SUM_RAW_W'(err_sat);
  assign sum_top = sum_raw[SUM_RAW_W-1:INTEGRAL_BITS-1];
  assign sum_sat = ((&sum_top) || !(|sum_top)) ? sum_raw[INTEGRAL_BITS-1:0]
                 : (sum_raw[SUM_RAW_W-1] ? INT_MIN : INT_MAX);

  assign err_abs = err_sat[POSITION_BITS-1]
                 ? (POSITION_BITS+1)'(0) - {err_sat[POSITION_BITS-1], err_sat}
                 : {1'b0, err_sat};
  assign tick_count_next = (tick_count == TICK_MAX) ? tick_count
                         : tick_count + TICK_W'(1);
  assign settled   = err_abs < (POSITION_BITS+1)'(move.settle_band);
  assign timed_out = tick_count_next >= move.max_ticks;

  always_comb begin
    track_next = '0;
    if (action == ACT_START) begin
      track_next.status = ST_RUNNING;
      track_next.hold   = 1'b1;
    end else if (run_status != ST_RUNNING) begin
      track_next.err    = last_error;
      track_next.status = run_status;
      track_next.hold   = 1'b1;
    end else begin
      track_next.err     = err_sat;
      track_next.err_sum = sum_sat;
      track_next.deriv   = DERIV_W'(err_sat) - DERIV_W'(last_error);
      track_next.hold    = settled;
      if (settled) begin
        track_next.status = ST_SETTLED;
      end else if (timed_out) begin
        track_next.status = ST_TIMEOUT;
      end else begin
        track_next.status = ST_RUNNING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_origin  <= '0;
      right_origin <= '0;
      error_sum    <= '0;
      last_error   <= '0;
      tick_count   <= '0;
      run_status   <= ST_IDLE;
    end else if (take) begin
      if (action == ACT_START) begin
        left_origin  <= left;
        right_origin <= right;
        error_sum    <= '0;
        last_error   <= '0;
        tick_count   <= '0;
        run_status   <= ST_RUNNING;
      end else if (run_status == ST_RUNNING) begin
        error_sum  <= sum_sat;
        last_error <= err_sat;
        tick_count <= tick_count_next;
        run_status <= track_next.status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      track <= track_next;
    end
  end

  assign out_valid = v2;
  assign out_track = track;

endmodule

>>> rtl/core/dpid_mac.sv
// ----------------------------------------------------------------------------
// dpid_mac
// Gain products, P+I+D sum and drive clamp, three register stages.
// ----------------------------------------------------------------------------
module dpid_mac (
  input  logic                                      clk,
  input  logic                                      rst,
  input  dpid_pkg::gain_set_t                       gains,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  dpid_pkg::track_t                          in_track,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [dpid_pkg::DRIVE_W-1:0]       drive_command,
  output dpid_pkg::status_t                         move_status,
  output logic signed [dpid_pkg::POSITION_BITS-1:0] position_error
);
  import dpid_pkg::*;

  logic                            va;
  logic signed [PP_W-1:0]          prod_p;
  logic signed [PILO_W-1:0]        prod_ilo;
  logic signed [PIHI_W-1:0]        prod_ihi;
  logic signed [PD_W-1:0]          prod_d;
  status_t                         status_a;
  logic                            hold_a;
  logic signed [POSITION_BITS-1:0] err_a;

  logic                            vb;
  logic signed [ACC_W-1:0]         acc;
  status_t                         status_b;
  logic                            hold_b;
  logic signed [POSITION_BITS-1:0] err_b;

  logic                            vc;
  logic signed [DRIVE_W-1:0]       drive;
  status_t                         status_c;
  logic signed [POSITION_BITS-1:0] err_c;

  logic                            adv_a;
  logic                            adv_b;
  logic                            adv_c;
  logic signed [ACC_W-1:0]         acc_next;
  logic signed [QUO_W-1:0]         quo;
  logic signed [QUO_W-1:0]         lim_pos;
  logic signed [QUO_W-1:0]         lim_neg;
  logic signed [DRIVE_W-1:0]       drive_next;

  assign adv_c    = !vc || out_ready;
  assign adv_b    = !vb || adv_c;
  assign adv_a    = !va || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (adv_a) begin
        va <= in_valid;
      end
      if (adv_b) begin
        vb <= va;
      end
      if (adv_c) begin
        vc <= vb;
      end
    end
  end

  // The integral is split in two halves to keep each product narrow.
  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      prod_p   <= PP_W'($signed(gains.p_gain)) * PP_W'($signed(in_track.err));
      prod_ilo <= PILO_W'($signed(gains.i_gain))
                * PILO_W'($signed({1'b0, in_track.err_sum[I_LO_W-1:0]}));
      prod_ihi <= PIHI_W'($signed(gains.i_gain))
                * PIHI_W'($signed(in_track.err_sum[INTEGRAL_BITS-1:I_LO_W]));
      prod_d   <= PD_W'($signed(gains.d_gain)) * PD_W'($signed(in_track.deriv));
      status_a <= in_track.status;
      hold_a   <= in_track.hold;
      err_a    <= in_track.err;
    end
  end

  assign acc_next = ACC_W'(prod_p) + ACC_W'(prod_d) + ACC_W'(prod_ilo)
                  + (ACC_W'(prod_ihi) <<< I_LO_W);

  always_ff @(posedge clk) begin
    if (adv_b && va) begin
      acc      <= acc_next;
      status_b <= status_a;
      hold_b   <= hold_a;
      err_b    <= err_a;
    end
  end

  // Arithmetic shift floors the quotient for either sign.
  assign quo     = acc[ACC_W-1:GAIN_SHIFT];
  assign lim_pos = QUO_W'({1'b0, gains.output_limit});
  assign lim_neg = QUO_W'(0) - lim_pos;

  always_comb begin
    if (hold_b) begin
      drive_next = '0;
    end else if (quo > lim_pos) begin
      drive_next = lim_pos[DRIVE_W-1:0];
    end else if (quo < lim_neg) begin
      drive_next = lim_neg[DRIVE_W-1:0];
    end else begin
      drive_next = quo[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c && vb) begin
      drive    <= drive_next;
      status_c <= status_b;
      err_c    <= err_b;
    end
  end

  assign out_valid      = vc;
  assign drive_command  = drive;
  assign move_status    = status_c;
  assign position_error = err_c;

endmodule

>>> rtl/core/drive_distance_pid.sv
// ----------------------------------------------------------------------------
// drive_distance_pid
// Drive-distance PID controller with integral saturation and output clamp.
//
//   channel   direction  handshake          contents
//   cfg       in         cfg_write          cfg_index, cfg_data
//   s_        in         tvalid / tready    tuser: action; tdata: positions
//   m_        out        tvalid / tready    tdata: drive, status, error
//
// One item is taken per cycle when the output side keeps up; a result
// passes the input register and the tracking register before the MAC stages.
// The loop from error to integral and tick state closes combinationally,
// and the gain products and clamp follow in three register stages.
// Every stage holds while the next one is full, so a stall on m_ reaches
// s_tready only after all stages are occupied.
// Reset is synchronous; it empties the pipeline, restores register defaults
// and leaves the controller idle.
// ----------------------------------------------------------------------------
module drive_distance_pid (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dpid_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dpid_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata: left_position, right_position
  input  logic [dpid_pkg::S_DATA_W-1:0]     s_tdata,
  // tuser: action
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata: drive_command, move_status, position_error
  output logic [dpid_pkg::M_DATA_W-1:0]     m_tdata
);
  import dpid_pkg::*;

  gain_set_t                       gains;
  move_set_t                       move;
  logic                            trk_valid;
  logic                            trk_ready;
  track_t                          trk;
  logic signed [DRIVE_W-1:0]       drive_command;
  status_t                         move_status;
  logic signed [POSITION_BITS-1:0] position_error;

  dpid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains),
    .move      (move)
  );

  dpid_track u_track (
    .clk       (clk),
    .rst       (rst),
    .move      (move),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_left   (s_tdata[POSITION_BITS-1:0]),
    .in_right  (s_tdata[2*POSITION_BITS-1:POSITION_BITS]),
    .out_valid (trk_valid),
    .out_ready (trk_ready),
    .out_track (trk)
  );

  dpid_mac u_mac (
    .clk            (clk),
    .rst            (rst),
    .gains          (gains),
    .in_valid       (trk_valid),
    .in_ready       (trk_ready),
    .in_track       (trk),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .drive_command  (drive_command),
    .move_status    (move_status),
    .position_error (position_error)
  );

  assign m_tdata = M_DATA_W'({position_error, move_status, drive_command});

endmodule

>>> rtl/core/dpid_checker.sv
// ----------------------------------------------------------------------------
// dpid_checker
// Port-level checks of the drive-distance PID block, bound to the top level.
// ----------------------------------------------------------------------------
module dpid_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dpid_pkg::M_DATA_W-1:0] m_tdata
);
  import dpid_pkg::*;

  logic [STATUS_W-1:0] out_status;
  logic [DRIVE_W-1:0]  out_drive;

  assign out_status = m_tdata[STATUS_LSB +: STATUS_W];
  assign out_drive  = m_tdata[DRIVE_LSB +: DRIVE_W];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_settled_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_SETTLED) |-> out_drive == '0)
    else $error("settled item carries a nonzero drive");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_IDLE) |-> out_drive == '0)
    else $error("idle item carries a nonzero drive");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind drive_distance_pid dpid_checker u_dpid_checker (.*);

>>> tb/drive_distance_pid_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drive_distance_pid_tb
// Self-checking bench for the drive-distance PID controller. A directed
// script covers reset, register extremes, position wrap, error saturation,
// settling and time-out. Random moves follow under four pacing modes on the
// input and output streams. Results are checked by predictor or script row.
// ----------------------------------------------------------------------------
module drive_distance_pid_tb;
  import dpid_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;
  localparam int BLOCK_ITEMS  = 58;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0]       drive;
    status_t                         status;
    logic signed [POSITION_BITS-1:0] err;
  } drive_result_t;

  typedef struct packed {
    row_kind_t                 kind;
    cfg_index_t                idx;
    logic [CFG_DATA_W-1:0]     val;
    logic                      act;
    logic [POSITION_BITS-1:0]  lpos;
    logic [POSITION_BITS-1:0]  rpos;
    logic                      typed;
    logic [DRIVE_W-1:0]        drive;
    status_t                   status;
    logic [POSITION_BITS-1:0]  err;
  } script_row_t;

  localparam int SCRIPT_ROWS = 38;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h0, 32'h0, 1'b1, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_START, 32'h0, 32'h0, 1'b1, 16'h0, ST_RUNNING, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h0, 32'h0, 1'b1, 16'h0, ST_SETTLED, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h0, 32'h0, 1'b1, 16'h0, ST_SETTLED, 32'h0},
    '{ROW_REG, REG_TARGET, 24'h7FFFFF, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_P_GAIN, 24'h7FFFFF, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_I_GAIN, 24'h800000, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_D_GAIN, 24'h7FFFFF, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_BAND, 24'h0, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_MAX, 24'h3, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_START, 32'h7FFFFFFF, 32'h80000000,
      1'b1, 16'h0, ST_RUNNING, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h80000000, 32'h7FFFFFFF,
      1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'hFFFFFFFF, 32'hFFFFFFFF,
      1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h7FFFFFFF, 32'h80000000,
      1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_START, 32'h7FFFFFFF, 32'h7FFFFFFF,
      1'b1, 16'h0, ST_RUNNING, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h80000000, 32'h80000000,
      1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_TARGET, 24'h800000, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_P_GAIN, 24'h800000, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_MAX, 24'h0, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_LIMIT, 24'h7FFF, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_START, 32'h80000000, 32'h80000000,
      1'b1, 16'h0, ST_RUNNING, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h7FFFFFFF, 32'h7FFFFFFF,
      1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_BAND, 24'hFFFF, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_LIMIT, 24'h0, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_MAX, 24'h3FF, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_TARGET, 24'h100, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_I_GAIN, 24'h0, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_D_GAIN, 24'h800000, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_START, 32'h00001000, 32'hFFFFF000,
      1'b1, 16'h0, ST_RUNNING, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h00001100, 32'hFFFFF100,
      1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_BAND, 24'h10, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_START, 32'h0, 32'h0, 1'b1, 16'h0, ST_RUNNING, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h55555555, 32'hAAAAAAAA,
      1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_REG, REG_LIMIT, 24'h6400, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'hAAAAAAAA, 32'h55555555,
      1'b0, 16'h0, ST_IDLE, 32'h0},
    '{ROW_ITEM, REG_TARGET, 24'h0, ACT_TICK, 32'h0, 32'h0, 1'b0, 16'h0, ST_IDLE, 32'h0}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [S_DATA_W-1:0]      s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [M_DATA_W-1:0]      m_tdata;

  // Predictor copy of the registers and the move state.
  logic signed [GAIN_W-1:0] tgt_dist = '0;
  logic signed [GAIN_W-1:0] kp = '0;
  logic signed [GAIN_W-1:0] ki = '0;
  logic signed [GAIN_W-1:0] kd = '0;
  logic [BAND_W-1:0]        band = 16'd80;
  logic [TICK_W-1:0]        tick_limit = 10'd150;
  logic [LIMIT_W-1:0]       drive_limit = 15'd25600;
  longint                   org_l = 0;
  longint                   org_r = 0;
  longint                   err_sum = 0;
  longint                   prev_err = 0;
  int                       ticks = 0;
  status_t                  run_st = ST_IDLE;

  drive_result_t            results_due [$];
  drive_result_t            want;
  drive_result_t            got;
  int                       src_idle_pct = 0;
  int                       rx_stall_pct = 0;
  int                       items_sent = 0;
  int                       results_seen = 0;
  int                       settled_seen = 0;
  int                       timeouts_seen = 0;
  int                       mismatches = 0;
  int                       setting_sets = 0;

  drive_distance_pid u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Target distance in 1/16 degree, rounded from the 1/256 inch register.
  function automatic longint target_counts();
    return (longint'(tgt_dist) * longint'(DIST_SCALE) + 32768) >>> ROUND_SHIFT;
  endfunction

  function automatic drive_result_t pid_step(input logic act,
                                             input logic signed [POSITION_BITS-1:0] lpos,
                                             input logic signed [POSITION_BITS-1:0] rpos);
    drive_result_t       res;
    longint              err;
    longint              lim;
    longint              e_abs;
    logic signed [127:0] acc;
    logic signed [127:0] q;
    res.drive = '0;
    res.err = '0;
    if (act == ACT_START) begin
      org_l = longint'(lpos);
      org_r = longint'(rpos);
      err_sum = 0;
      prev_err = 0;
      ticks = 0;
      run_st = ST_RUNNING;
      res.status = ST_RUNNING;
    end else if (run_st != ST_RUNNING) begin
      res.status = run_st;
      res.err = prev_err[POSITION_BITS-1:0];
    end else begin
      err = saturate(target_counts()
                     - ((longint'(lpos) - org_l + longint'(rpos) - org_r) >>> 1),
                     POSITION_BITS);
      err_sum = saturate(err_sum + err, INTEGRAL_BITS);
      acc = 128'(kp) * 128'(err) + 128'(ki) * 128'(err_sum)
          + 128'(kd) * 128'(err - prev_err);
      q = acc >>> GAIN_SHIFT;
      lim = longint'(drive_limit);
      if (q > 128'(lim)) begin
        q = 128'(lim);
      end else if (q < -128'(lim)) begin
        q = -128'(lim);
      end
      prev_err = err;
      if (ticks < int'(TICK_MAX)) ticks++;
      e_abs = (err < 0) ? -err : err;
      if (e_abs < longint'(band)) begin
        run_st = ST_SETTLED;
        q = '0;
      end else if (ticks >= int'(tick_limit)) begin
        run_st = ST_TIMEOUT;
      end
      res.drive = q[DRIVE_W-1:0];
      res.status = run_st;
      res.err = err[POSITION_BITS-1:0];
    end
    return res;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_gain();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom);
      default: return 24'($urandom_range(1 << 18) - (1 << 17));
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic send_item(input logic act, input logic [POSITION_BITS-1:0] lpos,
                           input logic [POSITION_BITS-1:0] rpos,
                           input logic use_given, input drive_result_t given);
    drive_result_t predicted;
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= S_DATA_W'({rpos, lpos});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = pid_step(act, lpos, rpos);
    results_due.push_back(use_given ? given : predicted);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TARGET: tgt_dist = val;
      REG_P_GAIN: kp = val;
      REG_I_GAIN: ki = val;
      REG_D_GAIN: kd = val;
      REG_BAND:   band = val[BAND_W-1:0];
      REG_MAX:    tick_limit = val[TICK_W-1:0];
      REG_LIMIT:  drive_limit = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
    setting_sets++;
  endtask

  always @(negedge clk) begin
    m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.drive  = m_tdata[DRIVE_LSB +: DRIVE_W];
      got.status = status_t'(m_tdata[STATUS_LSB +: STATUS_W]);
      got.err    = m_tdata[ERROR_LSB +: POSITION_BITS];
      results_seen++;
      if (got.status == ST_SETTLED) settled_seen++;
      if (got.status == ST_TIMEOUT) timeouts_seen++;
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("Unexpected result %0d: drive %0d status %0d error %0d",
                                results_seen, got.drive, got.status, got.err));
      end else begin
        want = results_due.pop_front();
        if (got.drive !== want.drive || got.status !== want.status
            || got.err !== want.err) begin
          flag_mismatch($sformatf({"Result %0d: expected drive %0d status %0d error %0d,",
                                   " got drive %0d status %0d error %0d"},
                                  results_seen, want.drive, want.status, want.err,
                                  got.drive, got.status, got.err));
        end
      end
    end
  end

  initial begin
    script_row_t              row;
    drive_result_t            given;
    logic                     writing;
    int                       directed_items;
    int                       phase;
    int                       blk;
    int                       quota;
    int                       steps;
    longint                   base_l;
    longint                   base_r;
    longint                   goal;
    longint                   prog;
    longint                   skew;
    logic [POSITION_BITS-1:0] lpos;
    logic [POSITION_BITS-1:0] rpos;

    writing = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      row = SCRIPT[r];
      if (row.kind == ROW_REG) begin
        if (!writing) wait_drained();
        write_reg(row.idx, row.val);
        writing = 1'b1;
      end else begin
        if (writing) end_writes();
        writing = 1'b0;
        given.drive = row.drive;
        given.status = row.status;
        given.err = row.err;
        send_item(row.act, row.lpos, row.rpos, row.typed, given);
      end
    end
    directed_items = items_sent;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin src_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin src_idle_pct = 32; rx_stall_pct = 32; end
      endcase
      for (blk = 0; blk < 2; blk++) begin
        wait_drained();
        case ($urandom_range(9))
          0: write_reg(REG_TARGET, 24'h7FFFFF);
          1: write_reg(REG_TARGET, 24'h800000);
          default: write_reg(REG_TARGET, 24'($urandom_range(40000) - 20000));
        endcase
        write_reg(REG_P_GAIN, random_gain());
        write_reg(REG_I_GAIN, random_gain());
        write_reg(REG_D_GAIN, random_gain());
        case ($urandom_range(9))
          0: write_reg(REG_BAND, 24'h0);
          1: write_reg(REG_BAND, 24'hFFFF);
          default: write_reg(REG_BAND, 24'($urandom_range(400)));
        endcase
        case ($urandom_range(9))
          0: write_reg(REG_MAX, 24'h0);
          1: write_reg(REG_MAX, 24'h3FF);
          default: write_reg(REG_MAX, 24'($urandom_range(25, 1)));
        endcase
        case ($urandom_range(9))
          0: write_reg(REG_LIMIT, 24'h0);
          1: write_reg(REG_LIMIT, 24'h7FFF);
          2: write_reg(REG_LIMIT, 24'h6400);
          default: write_reg(REG_LIMIT, 24'($urandom_range(25600)));
        endcase
        end_writes();

        quota = items_sent + BLOCK_ITEMS;
        while (items_sent < quota) begin
          if ($urandom_range(9) == 0) begin
            send_item(1'($urandom), $urandom, $urandom, 1'b0, given);
          end else begin
            // Origins near the wrap point now and then give huge deltas.
            case ($urandom_range(9))
              0: begin base_l = 64'h7FFFFF00; base_r = 64'h7FFFFF00; end
              1: begin base_l = 64'h80000000; base_r = 64'h7FFFFFFF; end
              default: begin base_l = longint'($urandom); base_r = longint'($urandom); end
            endcase
            send_item(ACT_START, base_l[POSITION_BITS-1:0], base_r[POSITION_BITS-1:0],
                      1'b0, given);
            goal = target_counts();
            steps = $urandom_range(24, 1);
            for (int j = 1; j <= steps; j++) begin
              prog = goal * j / steps + longint'($urandom_range(200)) - 100;
              skew = longint'($urandom_range(60)) - 30;
              lpos = POSITION_BITS'(base_l + prog + skew);
              rpos = POSITION_BITS'(base_r + prog - skew);
              send_item(ACT_TICK, lpos, rpos, 1'b0, given);
            end
          end
        end
      end
    end

    wait_drained();
    $display("Sent %0d items (%0d directed) under four pacing modes and %0d register sets.",
             items_sent, directed_items, setting_sets);
    $display("Checked %0d results: %0d settled and %0d timed-out reports, %0d mismatches.",
             results_seen, settled_seen, timeouts_seen, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/dpid_pkg.sv
rtl/core/dpid_cfg.sv
rtl/core/dpid_track.sv
rtl/core/dpid_mac.sv
rtl/core/drive_distance_pid.sv
rtl/core/dpid_checker.sv
tb/drive_distance_pid_tb.sv
